// ----- rtl/vkdg_pkg.sv -----
// Shared constants and widths for the volume knob deadband and gain block.
package vkdg_pkg;

	// Field widths
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned LEVEL_W  = 14;
	localparam int unsigned PCT_W    = 7;
	localparam int unsigned GAIN_W   = 9;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 14;

	// Level times percent fits in 21 bits (16383 * 100)
	localparam int unsigned PROD_W = LEVEL_W + PCT_W;

	// Defaults
	localparam int unsigned DECIMATION_DEF = 16;
	localparam logic [LEVEL_W-1:0] DEADBAND_RST = LEVEL_W'(64);
	localparam logic [PCT_W-1:0]   PCT_MAX      = PCT_W'(100);
	localparam logic [LEVEL_W-1:0] FULL_LEVEL   = LEVEL_W'(16383);
	localparam logic [GAIN_W-1:0]  GAIN_MAX     = GAIN_W'(256);

	// Gain = prod * 256 / GAIN_DIV, done as a multiply by a rounded-up
	// reciprocal; the error term stays below one for every product in range.
	localparam longint unsigned GAIN_DIV    = 64'd16383 * 64'd100;
	localparam int unsigned     GAIN_Q      = 8;
	localparam int unsigned     RECIP_SHIFT = 50;
	localparam int unsigned     RECIP_W     = 30;
	localparam longint unsigned RECIP_FULL  =
		((64'd1 << RECIP_SHIFT) + GAIN_DIV - 64'd1) / GAIN_DIV;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
	localparam int unsigned     RPROD_W     = PROD_W + RECIP_W;
	localparam int unsigned     GAIN_LSB    = RECIP_SHIFT - GAIN_Q;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KNOB_ENABLED = 2'd0,
		CFG_DEADBAND     = 2'd1,
		CFG_BT_MAX_PCT   = 2'd2,
		CFG_USB_MAX_PCT  = 2'd3
	} cfg_idx_t;

endpackage

// ----- rtl/vkdg_gain.sv -----
// Q8 gain from a level-times-percent product by reciprocal multiplication.
module vkdg_gain
	import vkdg_pkg::*;
(
	input  logic [PROD_W-1:0] prod,
	output logic [GAIN_W-1:0] gain
);

	logic [RPROD_W-1:0] rprod;

	// Scale by the reciprocal, keep the integer part
	assign rprod = RPROD_W'(prod) * RPROD_W'(RECIP);
	assign gain  = rprod[GAIN_LSB +: GAIN_W];

endmodule

// ----- rtl/volume_knob_deadband_gain_core.sv -----
// Top level: tick decimation, knob deadband and path gain pipeline.
//
//   channel   signals                                   direction
//   input     in_valid, in_ready, adc_sample            upstream -> block
//   output    out_valid, out_ready, volume_level,
//             bt_gain, usb_gain                         block -> downstream
//   config    cfg_we, cfg_index, cfg_data               host -> block
//
// One tick is accepted per cycle while in_ready is high. A sampling tick that
// passes the deadband reaches the outputs through the input register, then
// level-times-percent, then reciprocal multiply into the result register.
// Reset clears the divider, the held level and all stage valid bits.
// Each stage advances when the stage after it is empty or moving, so bubbles
// fill in while a result waits downstream.
module volume_knob_deadband_gain_core
	import vkdg_pkg::*;
#(
	parameter int unsigned DECIMATION = DECIMATION_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   adc_sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LEVEL_W-1:0]    volume_level,
	output logic [GAIN_W-1:0]     bt_gain,
	output logic [GAIN_W-1:0]     usb_gain,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned DIV_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
	localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(DECIMATION - 1);

	// Configuration registers
	logic               knob_enabled_q;
	logic [LEVEL_W-1:0] deadband_q;
	logic [PCT_W-1:0]   bt_pct_q;
	logic [PCT_W-1:0]   usb_pct_q;

	// Control state
	logic [DIV_W-1:0]   div_q;
	logic [LEVEL_W-1:0] last_level_q;
	logic               have_last_q;

	// Pipeline
	logic               v_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic               v_s2;
	logic [LEVEL_W-1:0] level_s2;
	logic [PROD_W-1:0]  bt_prod_s2;
	logic [PROD_W-1:0]  usb_prod_s2;

	logic               ready_s3;
	logic               ready_s2;
	logic               in_fire;
	logic               sample_tick;
	logic [PCT_W-1:0]   wr_pct;
	logic [LEVEL_W-1:0] level_in;
	logic [LEVEL_W-1:0] diff;
	logic               emit;
	logic [GAIN_W-1:0]  bt_gain_d;
	logic [GAIN_W-1:0]  usb_gain_d;

	// Stage handshakes
	assign ready_s3 = !out_valid || out_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign in_ready = !v_s1 || ready_s2;
	assign in_fire  = in_valid && in_ready;
	assign sample_tick = (div_q == DIV_LAST);

	// Saturate percent writes at the top of the range
	assign wr_pct = (cfg_data[PCT_W-1:0] > PCT_MAX) ? PCT_MAX : cfg_data[PCT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knob_enabled_q <= 1'b1;
			deadband_q     <= DEADBAND_RST;
			bt_pct_q       <= PCT_MAX;
			usb_pct_q      <= PCT_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KNOB_ENABLED: knob_enabled_q <= cfg_data[0];
				CFG_DEADBAND:     deadband_q     <= cfg_data[LEVEL_W-1:0];
				CFG_BT_MAX_PCT:   bt_pct_q       <= wr_pct;
				CFG_USB_MAX_PCT:  usb_pct_q      <= wr_pct;
				default: ;
			endcase
		end
	end

	// Advance the tick divider on every transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= '0;
		end else if (in_fire) begin
			div_q <= sample_tick ? '0 : div_q + DIV_W'(1);
		end
	end

	// Scale the sample, or force full scale when the knob is off
	assign level_in = knob_enabled_q ? {adc_sample, 2'b00} : FULL_LEVEL;

	// Stage 1: capture sampling ticks only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_fire && sample_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			level_s1 <= level_in;
		end
	end

	// Deadband check against the last accepted level
	assign diff = (level_s1 > last_level_q) ? (level_s1 - last_level_q)
	                                        : (last_level_q - level_s1);
	assign emit = v_s1 && (!have_last_q || (diff > deadband_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= '0;
			have_last_q  <= 1'b0;
		end else if (ready_s2 && emit) begin
			last_level_q <= level_s1;
			have_last_q  <= 1'b1;
		end
	end

	// Stage 2: level times percent for both paths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && emit) begin
			level_s2    <= level_s1;
			bt_prod_s2  <= PROD_W'(level_s1) * PROD_W'(bt_pct_q);
			usb_prod_s2 <= PROD_W'(level_s1) * PROD_W'(usb_pct_q);
		end
	end

	// Reciprocal multiply for each path
	vkdg_gain u_bt_gain (
		.prod (bt_prod_s2),
		.gain (bt_gain_d)
	);

	vkdg_gain u_usb_gain (
		.prod (usb_prod_s2),
		.gain (usb_gain_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_s3) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			volume_level <= level_s2;
			bt_gain      <= bt_gain_d;
			usb_gain     <= usb_gain_d;
		end
	end

	// Gains stay within unity
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bt_gain <= GAIN_MAX) && (usb_gain <= GAIN_MAX))
		else $error("gain above unity");

	// A level waiting in stage 2 is the one held for the deadband
	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (last_level_q == level_s2) && have_last_q)
		else $error("held level does not match stage 2");

	// Once a level is held it is never dropped
	a_have_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		have_last_q |=> have_last_q)
		else $error("held level flag cleared");

	// Input backpressure only comes from a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready && v_s2)
		else $error("input stalled without a full pipeline");

endmodule
